// ----- hw/rtl/supply_voltage_trimmed_mean_filter_macros.svh -----
// Assertion macros for the supply voltage trimmed mean filter
`ifndef SUPPLY_VOLTAGE_TRIMMED_MEAN_FILTER_MACROS_SVH
`define SUPPLY_VOLTAGE_TRIMMED_MEAN_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define SVTMF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define SVTMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define SVTMF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SVTMF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/svtmf_pkg.sv -----
// Shared constants, types and helpers for the supply voltage trimmed mean filter
package svtmf_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int MAX_WINDOW   = 8;
   localparam int WIN_BITS     = 4;
   localparam int MARGIN_BITS  = 16;
   localparam int NUM_CHAN     = 3;
   localparam int CHAN_BITS    = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int IDX_BITS     = $clog2(MAX_WINDOW);
   localparam int SUM_BITS     = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
   localparam int DIV_BITS     = SAMPLE_BITS + $clog2(MAX_WINDOW - 1);
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
   localparam int SEL_BITS     = MARGIN_BITS + 1;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [WIN_BITS-1:0]    window_type;

   localparam sample_type SAMPLE_MAX   = {SAMPLE_BITS{1'b1}};
   localparam window_type WINDOW_RESET = WIN_BITS'(5);

   localparam logic [CHAN_BITS-1:0] CH_FIRST   = CHAN_BITS'(0);
   localparam logic [CHAN_BITS-1:0] CH_SECOND  = CHAN_BITS'(1);
   localparam logic [CHAN_BITS-1:0] CH_BATTERY = CHAN_BITS'(2);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SELECT_MARGIN  = 2'd0,
      CSR_WINDOW_FIRST   = 2'd1,
      CSR_WINDOW_SECOND  = 2'd2,
      CSR_WINDOW_BATTERY = 2'd3
   } csr_index_type;

   // last history slot used by a window; also the trim divisor for windows of two or more
   function automatic logic [IDX_BITS-1:0] last_index(input window_type win);
      logic [WIN_BITS:0] w;
      if (win > WIN_BITS'(MAX_WINDOW - 1)) begin
         w = (WIN_BITS+1)'(MAX_WINDOW);
      end else begin
         w = {1'b0, win};
      end
      if (win <= WIN_BITS'(1)) begin
         return '0;
      end
      return IDX_BITS'(w - (WIN_BITS+1)'(1));
   endfunction

endpackage

// ----- hw/rtl/svtmf_if.sv -----
// Request and response channel interfaces of the supply voltage trimmed mean filter
interface svtmf_req_if import svtmf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type first_sample;
   sample_type second_sample;

   modport source (output valid, first_sample, second_sample, input ready);
   modport sink (input valid, first_sample, second_sample, output ready);
endinterface

interface svtmf_rsp_if import svtmf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type battery_raw;
   sample_type first_filtered;
   sample_type second_filtered;
   sample_type battery_filtered;
   logic       first_ready;
   logic       second_ready;
   logic       battery_ready;

   modport source (output valid, battery_raw, first_filtered, second_filtered,
                   battery_filtered, first_ready, second_ready, battery_ready,
                   input ready);
   modport sink (input valid, battery_raw, first_filtered, second_filtered,
                 battery_filtered, first_ready, second_ready, battery_ready,
                 output ready);
endinterface

// ----- hw/rtl/supply_voltage_trimmed_mean_filter.sv -----
// Supply voltage trimmed mean filter: battery selection and three trimmed mean channels
//
// Usage: req_chan carries one pair of supply samples per item; rsp_chan returns one
// item per request with the selected battery sample, the three filtered values and
// the three warm-up ready flags. csr_* writes the margin and the three windows; write
// them only while no item is in flight.
// An item is taken only while the sequencer is idle. The channels are then worked one
// after another by one accumulate unit that walks the history a slot per cycle and one
// bit-serial divider. A window of 0 skips both, a window of 1 skips the divider, and a
// window of two or more (capped at 8) spends most of its time in the divider. A new item
// is taken only once the last one has been handed to the output register. A finished
// response waits in an output register while the next item is accepted and processed;
// if the receiver still stalls when that item is done, the sequencer holds until the
// output register frees up.
// Reset (synchronous, active high) clears all histories and warm-up counters, sets the
// margin to 0 and every window to 5.
`include "supply_voltage_trimmed_mean_filter_macros.svh"

module supply_voltage_trimmed_mean_filter import svtmf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   svtmf_req_if.sink               req_chan,
   svtmf_rsp_if.source             rsp_chan,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [MARGIN_BITS-1:0]  csr_write_data
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_INIT = 7'b0000010,
      ST_ACC  = 7'b0000100,
      ST_TRIM = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_WB   = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CHAN_BITS-1:0]  ch_ff, ch_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [MARGIN_BITS-1:0] margin_ff, margin_in;
   window_type            win_ff [NUM_CHAN];
   window_type            win_in [NUM_CHAN];
   window_type            warm_ff [NUM_CHAN];
   window_type            warm_in [NUM_CHAN];
   sample_type            hist_ff [NUM_CHAN][MAX_WINDOW];
   sample_type            hist_in [NUM_CHAN][MAX_WINDOW];
   sample_type            x_ff [NUM_CHAN];
   sample_type            x_in [NUM_CHAN];
   sample_type            filt_ff [NUM_CHAN];
   sample_type            filt_in [NUM_CHAN];
   logic                  rdy_ff [NUM_CHAN];
   logic                  rdy_in [NUM_CHAN];
   logic [SUM_BITS-1:0]   total_ff, total_in;
   sample_type            hi_ff, hi_in;
   sample_type            lo_ff, lo_in;
   sample_type            res_ff, res_in;
   logic                  out_valid_ff, out_valid_in;
   sample_type            out_raw_ff, out_raw_in;
   sample_type            out_filt_ff [NUM_CHAN];
   sample_type            out_filt_in [NUM_CHAN];
   logic                  out_rdy_ff [NUM_CHAN];
   logic                  out_rdy_in [NUM_CHAN];

   logic                  req_fire;
   logic                  rsp_fire;
   logic                  out_free;
   logic                  pick_first;
   window_type            cur_win;
   sample_type            cur_x;
   sample_type            cur_v;
   logic [IDX_BITS-1:0]   cur_last;
   logic [SUM_BITS-1:0]   trimmed;
   logic                  div_start;
   logic                  div_done;
   logic [DIV_BITS-1:0]   div_quo;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign rsp_fire   = rsp_chan.valid && rsp_chan.ready;
   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign pick_first = SEL_BITS'(req_chan.first_sample) >
                       SEL_BITS'(req_chan.second_sample) + SEL_BITS'(margin_ff);
   assign cur_win    = win_ff[ch_ff];
   assign cur_x      = x_ff[ch_ff];
   assign cur_v      = hist_ff[ch_ff][idx_ff];
   assign cur_last   = last_index(cur_win);
   assign trimmed    = total_ff - SUM_BITS'(hi_ff) - SUM_BITS'(lo_ff);

   svtmf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (trimmed[DIV_BITS-1:0]),
      .divisor  (cur_last),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      idx_in       = idx_ff;
      margin_in    = margin_ff;
      win_in       = win_ff;
      warm_in      = warm_ff;
      hist_in      = hist_ff;
      x_in         = x_ff;
      filt_in      = filt_ff;
      rdy_in       = rdy_ff;
      total_in     = total_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      res_in       = res_ff;
      out_valid_in = rsp_fire ? 1'b0 : out_valid_ff;
      out_raw_in   = out_raw_ff;
      out_filt_in  = out_filt_ff;
      out_rdy_in   = out_rdy_ff;
      div_start    = 1'b0;

      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SELECT_MARGIN:  margin_in = csr_write_data;
            CSR_WINDOW_FIRST:   win_in[CH_FIRST] = csr_write_data[WIN_BITS-1:0];
            CSR_WINDOW_SECOND:  win_in[CH_SECOND] = csr_write_data[WIN_BITS-1:0];
            CSR_WINDOW_BATTERY: win_in[CH_BATTERY] = csr_write_data[WIN_BITS-1:0];
            default:            margin_in = margin_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in[CH_FIRST]   = req_chan.first_sample;
               x_in[CH_SECOND]  = req_chan.second_sample;
               x_in[CH_BATTERY] = pick_first ? req_chan.first_sample
                                             : req_chan.second_sample;
               ch_in    = CH_FIRST;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            total_in = SUM_BITS'(cur_x);
            hi_in    = cur_x;
            lo_in    = cur_x;
            idx_in   = '0;
            if (cur_win == '0) begin
               res_in   = cur_x;
               state_in = ST_WB;
            end else begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            total_in = total_ff + SUM_BITS'(cur_v);
            if (cur_v > hi_ff) begin
               hi_in = cur_v;
            end
            if (cur_v < lo_ff) begin
               lo_in = cur_v;
            end
            if (idx_ff == cur_last) begin
               state_in = ST_TRIM;
            end else begin
               idx_in = idx_ff + IDX_BITS'(1);
            end
         end
         ST_TRIM: begin
            if (cur_win == WIN_BITS'(1)) begin
               res_in   = total_ff[SAMPLE_BITS:1];
               state_in = ST_WB;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = (div_quo > DIV_BITS'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                            : div_quo[SAMPLE_BITS-1:0];
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            filt_in[ch_ff] = res_ff;
            rdy_in[ch_ff]  = warm_ff[ch_ff] >= cur_win;
            if (warm_ff[ch_ff] < cur_win) begin
               warm_in[ch_ff] = warm_ff[ch_ff] + WIN_BITS'(1);
            end
            if (cur_win != '0) begin
               for (int k = 0; k < MAX_WINDOW; k++) begin
                  if (k == 0) begin
                     hist_in[ch_ff][k] = cur_x;
                  end else if (IDX_BITS'(k) <= cur_last) begin
                     hist_in[ch_ff][k] = hist_ff[ch_ff][k-1];
                  end
               end
            end
            if (ch_ff == CH_BATTERY) begin
               state_in = ST_DONE;
            end else begin
               ch_in    = ch_ff + CHAN_BITS'(1);
               state_in = ST_INIT;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_raw_in   = x_ff[CH_BATTERY];
               out_filt_in  = filt_ff;
               out_rdy_in   = rdy_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= CH_FIRST;
         idx_ff       <= '0;
         margin_ff    <= '0;
         out_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CHAN; c++) begin
            win_ff[c]  <= WINDOW_RESET;
            warm_ff[c] <= '0;
            for (int k = 0; k < MAX_WINDOW; k++) begin
               hist_ff[c][k] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         idx_ff       <= idx_in;
         margin_ff    <= margin_in;
         out_valid_ff <= out_valid_in;
         win_ff       <= win_in;
         warm_ff      <= warm_in;
         hist_ff      <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      filt_ff     <= filt_in;
      rdy_ff      <= rdy_in;
      total_ff    <= total_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      res_ff      <= res_in;
      out_raw_ff  <= out_raw_in;
      out_filt_ff <= out_filt_in;
      out_rdy_ff  <= out_rdy_in;
   end

   assign req_chan.ready            = state_ff == ST_IDLE;
   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.battery_raw      = out_raw_ff;
   assign rsp_chan.first_filtered   = out_filt_ff[CH_FIRST];
   assign rsp_chan.second_filtered  = out_filt_ff[CH_SECOND];
   assign rsp_chan.battery_filtered = out_filt_ff[CH_BATTERY];
   assign rsp_chan.first_ready      = out_rdy_ff[CH_FIRST];
   assign rsp_chan.second_ready     = out_rdy_ff[CH_SECOND];
   assign rsp_chan.battery_ready    = out_rdy_ff[CH_BATTERY];

   `SVTMF_ASSERT_IMPLY(a_div_done_in_div, clock, reset, div_done, state_ff == ST_DIV)
   `SVTMF_ASSERT_IMPLY(a_walk_in_window, clock, reset, state_ff == ST_ACC, idx_ff <= cur_last)
   `SVTMF_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, state_ff == ST_INIT && ch_ff == CH_FIRST)
   `SVTMF_ASSERT_NEXT(a_done_loads, clock, reset, state_ff == ST_DONE && out_free, out_valid_ff && state_ff == ST_IDLE)

endmodule

// ----- hw/rtl/svtmf_div.sv -----
// Bit-serial restoring divider for the trimmed sum by the count of samples left after trimming (window minus one)
module svtmf_div import svtmf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] dividend,
   input  logic [IDX_BITS-1:0] divisor,
   output logic                done,
   output logic [DIV_BITS-1:0] quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]     rem_ff, rem_in;
   logic [IDX_BITS-1:0]     dvs_ff, dvs_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [IDX_BITS:0]       trial;
   logic [IDX_BITS:0]       diff;
   logic                    fits;

   assign trial = {rem_ff, quo_ff[DIV_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[IDX_BITS-1:0] : trial[IDX_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
